@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int SIZE_W       = 11;
    localparam int IN_DATA_W    = 112;
    localparam int OUT_DATA_W   = 80;

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_RANGE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

@@ design/spq_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
`default_nettype none
module spq_mem #(
    parameter int DEPTH = spq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire spq_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry      o_rdata
);
    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ design/sorted_priority_queue_with_update.sv @@
// Top level: sorted priority queue with key update, slots held in one memory.
// Enqueue, dequeue and range walk the stored slots one step at a time, and output stalls
// hold them; each slot step is a memory read and then a compare or write-back, set by the
// single read port.
// One item at a time: the next beat is taken only once the sequencer is back in idle, after the last result is staged.
// Synchronous active-low reset empties the queue and drops any pending result.
`default_nettype none
module sorted_priority_queue_with_update #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: key[31:0], range_end[63:32], value[95:64], size[106:96], zero pad
    input  wire logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: out_key[31:0], out_value[63:32], out_size[74:64], zero pad
    output logic [spq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: success
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam logic [OW-1:0] CAP_CNT = OW'(CAPACITY);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_FIND_RD = 12'b0000_0000_0010,
        S_FIND_CP = 12'b0000_0000_0100,
        S_UP_RD   = 12'b0000_0000_1000,
        S_UP_WR   = 12'b0000_0001_0000,
        S_DEQ_CP  = 12'b0000_0010_0000,
        S_DN_RD   = 12'b0000_0100_0000,
        S_DN_WR   = 12'b0000_1000_0000,
        S_RNG_RD  = 12'b0001_0000_0000,
        S_RNG_CP  = 12'b0010_0000_0000,
        S_RNG_END = 12'b0100_0000_0000,
        S_EMIT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [OW-1:0] r_occ, n_occ, r_idx, n_idx, r_pos, n_pos;
    spq_pkg::t_entry r_in, n_in, r_res, n_res, r_pend, n_pend;
    logic [spq_pkg::KEY_W-1:0] r_end, n_end;
    logic r_ok, n_ok, r_pend_v, n_pend_v;
    logic r_ov, n_ov, r_olast, n_olast, r_ook, n_ook;
    spq_pkg::t_entry r_odat, n_odat;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    spq_pkg::t_entry mem_wdata, rdata;
    logic [OW-1:0] idx_dec, idx_inc;
    logic out_free, in_beat, hit;
    spq_pkg::t_entry zero_e;

    spq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;
    assign idx_dec  = r_idx - 1'b1;
    assign idx_inc  = r_idx + 1'b1;
    assign zero_e   = '0;
    assign hit      = (rdata.key >= r_in.key) && (rdata.key <= r_end);

    // sequencer
    always_comb begin
        n_state = r_state; n_occ = r_occ; n_idx = r_idx; n_pos = r_pos;
        n_in = r_in; n_end = r_end; n_res = r_res; n_ok = r_ok;
        n_pend = r_pend; n_pend_v = r_pend_v;
        n_ov = r_ov && !m_axis_tready; n_olast = r_olast; n_ook = r_ook; n_odat = r_odat;
        mem_we = 1'b0; mem_waddr = r_idx[AW-1:0]; mem_wdata = rdata;
        mem_re = 1'b0; mem_raddr = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_in.key   = s_axis_tdata[31:0];
                    n_end      = s_axis_tdata[63:32];
                    n_in.value = s_axis_tdata[95:64];
                    n_in.size  = s_axis_tdata[106:96];
                    n_idx = '0; n_pend_v = 1'b0;
                    n_res = zero_e; n_ok = 1'b0;
                    case (s_axis_tuser)
                        spq_pkg::ACT_ENQ:
                            n_state = (s_axis_tdata[106:96] == '0) ? S_EMIT : S_FIND_RD;
                        spq_pkg::ACT_DEQ: begin
                            if (r_occ == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                mem_re = 1'b1; mem_raddr = '0;
                                n_state = S_DEQ_CP;
                            end
                        end
                        spq_pkg::ACT_RANGE: n_state = S_RNG_RD;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_idx == r_occ) begin
                    n_pos = r_idx;
                    n_state = (r_occ >= CAP_CNT) ? S_EMIT : S_UP_RD;
                end else begin
                    mem_re = 1'b1;
                    n_state = S_FIND_CP;
                end
            end
            S_FIND_CP: begin
                if (r_in.key < rdata.key) begin
                    n_idx = idx_inc;
                    n_state = S_FIND_RD;
                end else if (r_in.key == rdata.key) begin
                    mem_we = 1'b1; mem_wdata = r_in;
                    n_res = r_in; n_ok = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_idx; n_idx = r_occ;
                    n_state = (r_occ >= CAP_CNT) ? S_EMIT : S_UP_RD;
                end
            end
            // open a gap at the sorted place, walking down from the end
            S_UP_RD: begin
                if (r_idx == r_pos) begin
                    mem_we = 1'b1; mem_wdata = r_in;
                    n_occ = r_occ + 1'b1;
                    n_res = r_in; n_ok = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    mem_re = 1'b1; mem_raddr = idx_dec[AW-1:0];
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                mem_we = 1'b1;
                n_idx = idx_dec;
                n_state = S_UP_RD;
            end
            S_DEQ_CP: begin
                n_res = rdata; n_ok = 1'b1;
                n_state = S_DN_RD;
            end
            // close the gap at the head
            S_DN_RD: begin
                if (idx_inc >= r_occ) begin
                    n_occ = r_occ - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    mem_re = 1'b1; mem_raddr = idx_inc[AW-1:0];
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                mem_we = 1'b1;
                n_idx = idx_inc;
                n_state = S_DN_RD;
            end
            S_RNG_RD: begin
                if (r_idx == r_occ) begin
                    n_state = S_RNG_END;
                end else begin
                    mem_re = 1'b1;
                    n_state = S_RNG_CP;
                end
            end
            // a match is held back one step so the final one can carry last
            S_RNG_CP: begin
                if (!hit) begin
                    n_idx = idx_inc; n_state = S_RNG_RD;
                end else if (!r_pend_v) begin
                    n_pend = rdata; n_pend_v = 1'b1;
                    n_idx = idx_inc; n_state = S_RNG_RD;
                end else if (out_free) begin
                    n_ov = 1'b1; n_odat = r_pend; n_ook = 1'b1; n_olast = 1'b0;
                    n_pend = rdata;
                    n_idx = idx_inc; n_state = S_RNG_RD;
                end
            end
            S_RNG_END: begin
                if (r_pend_v) begin
                    n_res = r_pend; n_ok = 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_odat = r_res; n_ook = r_ok; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_ov    <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_pos <= n_pos; r_in <= n_in; r_end <= n_end;
        r_res <= n_res; r_ok <= n_ok; r_pend <= n_pend; r_pend_v <= n_pend_v;
        r_odat <= n_odat; r_ook <= n_ook; r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_ook ? r_odat : zero_e};
    assign m_axis_tuser  = r_ook;
    assign m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

@@ design/spq_chk.sv @@
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // a failed beat is all zero and ends its item
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && m_axis_tlast)
        else $error("failed beat not zero or not last");

    // only range matches come without last, and they always succeed
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-last beat without success");

    // nothing is offered right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");
endmodule

bind sorted_priority_queue_with_update spq_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ verif/tb_sorted_priority_queue_with_update.sv @@
// Testbench for the sorted priority queue: directed and random operations checked per beat.
`default_nettype none
module tb_sorted_priority_queue_with_update;

    localparam int CAP        = spq_pkg::CAPACITY_DEF;
    localparam int STALL_LIM  = 20000;

    typedef struct {
        logic        ok;
        logic [31:0] key;
        logic [31:0] value;
        logic [10:0] size;
        logic        last;
    } t_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    // Shadow copy of the queue contents
    logic [31:0] q_key   [CAP];
    logic [31:0] q_value [CAP];
    logic [10:0] q_size  [CAP];
    int          q_count;

    t_result pending_results[$];
    int      n_errors;
    int      n_beats_out;
    int      n_items_in;
    int      idle_pct;
    bit      hold_off;
    int      quiet_cycles;

    sorted_priority_queue_with_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_result fail_result();
        t_result r;
        r = '{1'b0, 32'd0, 32'd0, 11'd0, 1'b1};
        return r;
    endfunction

    function automatic t_result slot_result(int i, logic last);
        t_result r;
        r = '{1'b1, q_key[i], q_value[i], q_size[i], last};
        return r;
    endfunction

    // Update the shadow queue and push the beats this operation should produce
    task automatic predict_queue_op(spq_pkg::t_action act, logic [31:0] key,
                                    logic [31:0] hi, logic [31:0] val, logic [10:0] sz);
        int p;
        int nmatch;
        if (act == spq_pkg::ACT_ENQ) begin
            if (sz == 0) begin
                pending_results.push_back(fail_result());
                return;
            end
            p = 0;
            while (p < q_count && key < q_key[p]) p++;
            if (p < q_count && q_key[p] == key) begin
                q_value[p] = val;
                q_size[p]  = sz;
                pending_results.push_back(slot_result(p, 1'b1));
            end else if (q_count >= CAP) begin
                pending_results.push_back(fail_result());
            end else begin
                for (int i = q_count; i > p; i--) begin
                    q_key[i]   = q_key[i-1];
                    q_value[i] = q_value[i-1];
                    q_size[i]  = q_size[i-1];
                end
                q_key[p]   = key;
                q_value[p] = val;
                q_size[p]  = sz;
                q_count++;
                pending_results.push_back(slot_result(p, 1'b1));
            end
        end else if (act == spq_pkg::ACT_DEQ) begin
            if (q_count == 0) begin
                pending_results.push_back(fail_result());
                return;
            end
            pending_results.push_back(slot_result(0, 1'b1));
            for (int i = 0; i + 1 < q_count; i++) begin
                q_key[i]   = q_key[i+1];
                q_value[i] = q_value[i+1];
                q_size[i]  = q_size[i+1];
            end
            q_count--;
        end else if (act == spq_pkg::ACT_RANGE) begin
            nmatch = 0;
            for (int i = 0; i < q_count; i++)
                if (q_key[i] >= key && q_key[i] <= hi) nmatch++;
            if (nmatch == 0) begin
                pending_results.push_back(fail_result());
                return;
            end
            for (int i = 0; i < q_count; i++)
                if (q_key[i] >= key && q_key[i] <= hi) begin
                    nmatch--;
                    pending_results.push_back(slot_result(i, nmatch == 0));
                end
        end else begin
            pending_results.push_back(fail_result());
        end
    endtask

    // Drive one item and hold it until accepted; valid stays up for a following item
    task automatic send_op(spq_pkg::t_action act, logic [31:0] key, logic [31:0] hi,
                           logic [31:0] val, logic [10:0] sz);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, sz, val, hi, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_queue_op(act, key, hi, val, sz);
        n_items_in++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (2 * CAP + 8) @(negedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch on beat %0d: %s got %h expected %h", n_beats_out, what, got, exp);
        n_errors++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat key", m_axis_tdata[31:0], 32'd0);
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.ok)
                    report_mismatch("success", 32'(m_axis_tuser), 32'(e.ok));
                if (m_axis_tdata[31:0] !== e.key)
                    report_mismatch("key", m_axis_tdata[31:0], e.key);
                if (m_axis_tdata[63:32] !== e.value)
                    report_mismatch("value", m_axis_tdata[63:32], e.value);
                if (m_axis_tdata[74:64] !== e.size)
                    report_mismatch("size", 32'(m_axis_tdata[74:64]), 32'(e.size));
                if (m_axis_tlast !== e.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(e.last));
            end
            n_beats_out++;
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= !(idle_pct > 0 && $urandom_range(99, 0) < idle_pct);
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
            $display("watchdog timeout, %0d beats still expected", pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(40, 0) << 26 | $urandom_range(3, 0);
        endcase
    endfunction

    task automatic test_directed_edges();
        send_op(spq_pkg::ACT_DEQ, 32'd0, 32'd0, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_RANGE, 32'd0, 32'hFFFF_FFFF, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_ENQ, 32'd5, 32'd0, 32'hAAAA_5555, 11'd0);
        send_op(spq_pkg::ACT_ENQ, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024);
        send_op(spq_pkg::ACT_ENQ, 32'hFFFF_FFFF, 32'd0, 32'd0, 11'h7FF);
        send_op(spq_pkg::ACT_ENQ, 32'h8000_0000, 32'h5555_AAAA, 32'h1234_5678, 11'd1);
        send_op(spq_pkg::ACT_ENQ, 32'h8000_0000, 32'd0, 32'h8765_4321, 11'h555);
        send_op(spq_pkg::ACT_RANGE, 32'd0, 32'hFFFF_FFFF, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_RANGE, 32'h8000_0000, 32'h8000_0000, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_RANGE, 32'h9000_0000, 32'h1000_0000, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF);
        send_op(spq_pkg::ACT_DEQ, 32'd0, 32'd0, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_DEQ, 32'd0, 32'd0, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_DEQ, 32'd0, 32'd0, 32'd0, 11'd0);
        send_op(spq_pkg::ACT_DEQ, 32'd0, 32'd0, 32'd0, 11'd0);
        wait_drained();
    endtask

    // Fill past capacity, update while full, then range over everything
    task automatic test_full_queue();
        for (int i = 0; i < CAP + 2; i++)
            send_op(spq_pkg::ACT_ENQ, 32'(i) * 32'h0F00_0000 + 32'd7, 32'd0, $urandom,
                    11'($urandom_range(1024, 1)));
        send_op(spq_pkg::ACT_ENQ, 32'd7, 32'd0, 32'hDEAD_BEEF, 11'd3);
        send_op(spq_pkg::ACT_RANGE, 32'd0, 32'hFFFF_FFFF, 32'd0, 11'd0);
        wait_drained();
    endtask

    task automatic test_backpressure_fill();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_op(spq_pkg::t_action'($urandom_range(2, 0)), pick_key(), pick_key(),
                        $urandom, 11'($urandom_range(1024, 0)));
        join
        wait_drained();
    endtask

    task automatic test_random_ops(int count);
        spq_pkg::t_action act;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) idle_pct = 0;
            if (i == count / 2) idle_pct = 31;
            case ($urandom_range(9, 0))
                0, 1, 2, 3: act = spq_pkg::ACT_ENQ;
                4, 5:       act = spq_pkg::ACT_DEQ;
                6, 7, 8:    act = spq_pkg::ACT_RANGE;
                default:    act = spq_pkg::t_action'($urandom_range(3, 0));
            endcase
            send_op(act, pick_key(),
                    ($urandom_range(3, 0) == 0) ? $urandom : pick_key() | 32'h0FFF_FFFF,
                    $urandom, ($urandom_range(9, 0) == 0) ? 11'($urandom_range(2047, 0))
                                                           : 11'($urandom_range(1024, 0)));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        hold_off      = 1'b0;
        idle_pct      = 31;
        quiet_cycles  = 0;
        n_errors      = 0;
        n_beats_out   = 0;
        n_items_in    = 0;
        q_count       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_full_queue();
        test_backpressure_fill();
        test_random_ops(140);

        $display("covered %0d operations and %0d result beats, including full, empty,",
                 n_items_in, n_beats_out);
        $display("update, zero size, unused action and backpressure cases");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
